// ===== rtl/dlps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlps_pkg: shared types and constants for the lease pool server
// Beat structs, entry state codes, reply kinds, register indexes.
// ----------------------------------------------------------------------------
package dlps_pkg;

    localparam int POOL_SIZE_DEF = 64;

    typedef enum logic [1:0] {
        ST_FREE     = 2'd0,
        ST_PENDING  = 2'd1,
        ST_OCCUPIED = 2'd2,
        ST_EXPIRED  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        KIND_OFR = 2'd0,
        KIND_ACK = 2'd1,
        KIND_NAK = 2'd2,
        KIND_RSV = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CMD_DIS = 2'd0,
        CMD_REQ = 2'd1,
        CMD_OT2 = 2'd2,
        CMD_OT3 = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_SERVER_ID = 2'd0,
        REG_LEASE_DEF = 2'd1,
        REG_LEASE_MAX = 2'd2,
        REG_LEASE_MIN = 2'd3
    } t_reg;

    // cell operation broadcast along the chain
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_SWEEP  = 3'd1,
        OP_CLAIM  = 3'd2,
        OP_ACK    = 3'd3,
        OP_RELEASE = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_SWEEP = 3'd1,
        S_SCAN  = 3'd2,
        S_WAIT  = 3'd3,
        S_APPLY = 3'd4,
        S_REPLY = 3'd5
    } t_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [30:0] msg_time;
        logic [31:0] client_id;
        logic        dest_broadcast;
        logic [31:0] dest_id;
        logic [31:0] req_addr;
        logic [30:0] req_expiry;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  reply_kind;
        logic [31:0] reply_client;
        logic [31:0] reply_addr;
        logic [31:0] reply_expiry;
    } t_out_beat;

    // per-cell command from the controller
    typedef struct packed {
        t_op         op;
        logic [31:0] now;
        logic [31:0] client;
        logic [31:0] deadline;
    } t_cell_cmd;

    // search token handed cell to cell: first match of each class
    typedef struct packed {
        logic        own_hit;
        logic        free_hit;
        logic        exp_hit;
        logic [10:0] own_idx;
        logic [10:0] free_idx;
        logic [10:0] exp_idx;
    } t_token;

endpackage

// ===== rtl/dlps_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlps_cell: one pool entry
// Holds status, deadline and owner; updates on the broadcast command and
// folds its own match into the search token passed to the next cell.
// ----------------------------------------------------------------------------
module dlps_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [10:0]        i_idx,
    input  dlps_pkg::t_cell_cmd i_cmd,
    input  logic               i_sel,
    input  dlps_pkg::t_token   i_tok,
    output dlps_pkg::t_token   o_tok,
    output logic [31:0]        o_owner
);
    import dlps_pkg::*;

    t_status     r_status;
    logic [31:0] r_deadline;
    logic [31:0] r_owner;
    t_token      r_tok;

    logic due;
    assign due = (r_deadline != 32'd0) && (r_deadline <= i_cmd.now);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status   <= ST_FREE;
            r_deadline <= '0;
            r_owner    <= '0;
        end else begin
            case (i_cmd.op)
                OP_SWEEP: begin
                    if (due) begin
                        if (r_status == ST_PENDING) begin
                            r_status <= ST_FREE;
                            r_owner  <= '0;
                        end else begin
                            r_status <= ST_EXPIRED;
                        end
                        r_deadline <= '0;
                    end
                end
                OP_CLAIM: begin
                    if (i_sel) begin
                        r_status   <= ST_PENDING;
                        r_deadline <= i_cmd.deadline;
                        r_owner    <= i_cmd.client;
                    end
                end
                OP_ACK: begin
                    if (i_sel) begin
                        r_status   <= ST_OCCUPIED;
                        r_deadline <= i_cmd.deadline;
                    end
                end
                OP_RELEASE: begin
                    if (i_cmd.client != 32'd0 && r_owner == i_cmd.client
                        && r_status == ST_PENDING) begin
                        r_status   <= ST_FREE;
                        r_deadline <= '0;
                        r_owner    <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // token stage: registered, one cell per cycle
    t_token n_tok;
    always_comb begin
        n_tok = i_tok;
        if (!i_tok.own_hit && i_cmd.client != 32'd0 && r_owner == i_cmd.client) begin
            n_tok.own_hit = 1'b1;
            n_tok.own_idx = i_idx;
        end
        if (!i_tok.free_hit && r_status == ST_FREE) begin
            n_tok.free_hit = 1'b1;
            n_tok.free_idx = i_idx;
        end
        if (!i_tok.exp_hit && r_status == ST_EXPIRED) begin
            n_tok.exp_hit = 1'b1;
            n_tok.exp_idx = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    assign o_tok   = r_tok;
    assign o_owner = r_owner;

endmodule

// ===== rtl/dhcp_lease_pool_server.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcp_lease_pool_server: address lease pool
// Expiry sweep, then a token walks the cell chain to find the address.
// ----------------------------------------------------------------------------
// Dropped messages are not taken into the walk; accepted ones go through the
// sweep, the chain walk of one cell per cycle and the apply step before any
// o_valid strobe. One message at a time; busy is high for the whole walk.
// A new message is accepted only after the previous one has passed its reply state.
// Reset (synchronous, active low) frees every entry and loads register
// defaults. The receiver cannot stall: o_valid is a one-cycle strobe.
module dhcp_lease_pool_server #(
    parameter int POOL_SIZE = dlps_pkg::POOL_SIZE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  dlps_pkg::t_in_beat  i_in,
    output logic                o_valid,
    output dlps_pkg::t_out_beat o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import dlps_pkg::*;

    localparam int CW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int WALK = POOL_SIZE;

    // configuration registers
    logic [31:0] r_server_id;
    logic [30:0] r_lease_def, r_lease_max, r_lease_min;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_id <= 32'd1;
            r_lease_def <= 31'd3600;
            r_lease_max <= 31'd86400;
            r_lease_min <= 31'd60;
        end else if (i_cfg_valid) begin
            case (t_reg'(i_cfg_index))
                REG_SERVER_ID: r_server_id <= i_cfg_data;
                REG_LEASE_DEF: r_lease_def <= i_cfg_data[30:0];
                REG_LEASE_MAX: r_lease_max <= i_cfg_data[30:0];
                REG_LEASE_MIN: r_lease_min <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // message register and controller
    t_state      r_state, n_state;
    t_in_beat    r_msg;
    logic [10:0] r_cnt;
    logic [31:0] r_grant;
    logic        r_pick_ok;
    logic [10:0] r_pick;
    logic        r_nak;
    t_out_beat   r_out;
    logic        r_valid;

    logic accept, keep;
    assign accept = start && !busy;
    assign keep = (i_in.cmd == CMD_DIS && i_in.dest_broadcast)
               || (i_in.cmd == CMD_REQ && !i_in.dest_broadcast);
    assign busy = (r_state != S_IDLE);

    // lease grant: one signed compare path per bound
    logic signed [32:0] x_diff;
    logic [31:0] grant;
    always_comb begin
        x_diff = $signed({2'b00, r_msg.req_expiry}) - $signed({2'b00, r_msg.msg_time});
        if (r_msg.req_expiry == 31'd0)
            grant = {1'b0, r_msg.msg_time} + {1'b0, r_lease_def};
        else if (x_diff > $signed({2'b00, r_lease_max}))
            grant = {1'b0, r_msg.msg_time} + {1'b0, r_lease_max};
        else if (x_diff < $signed({2'b00, r_lease_min}))
            grant = {1'b0, r_msg.msg_time} + {1'b0, r_lease_min};
        else
            grant = {1'b0, r_msg.req_expiry};
    end

    // chain
    t_token     tok [0:POOL_SIZE];
    logic [31:0] owners [0:POOL_SIZE-1];
    t_cell_cmd  ccmd;
    logic [POOL_SIZE-1:0] sel;

    logic to_me;
    assign to_me = (r_msg.dest_id == r_server_id);
    logic addr_ok;
    assign addr_ok = (r_msg.req_addr >= 32'd1)
                  && (r_msg.req_addr <= 32'(POOL_SIZE));
    logic [CW-1:0] aidx;
    assign aidx = CW'(r_msg.req_addr - 32'd1);

    assign tok[0] = '0;

    always_comb begin
        ccmd.op       = OP_NONE;
        ccmd.now      = {1'b0, r_msg.msg_time};
        ccmd.client   = r_msg.client_id;
        ccmd.deadline = r_grant;
        case (r_state)
            S_SWEEP: ccmd.op = OP_SWEEP;
            S_APPLY: begin
                if (r_msg.cmd == CMD_DIS) begin
                    if (r_pick_ok) ccmd.op = OP_CLAIM;
                end else if (to_me) begin
                    if (!r_nak) ccmd.op = OP_ACK;
                end else begin
                    ccmd.op = OP_RELEASE;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        sel = '0;
        if (r_msg.cmd == CMD_DIS)
            sel[r_pick[CW-1:0]] = 1'b1;
        else
            sel[aidx] = 1'b1;
    end

    genvar g;
    generate
        for (g = 0; g < POOL_SIZE; g++) begin : g_cell
            dlps_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_idx   (11'(g)),
                .i_cmd   (ccmd),
                .i_sel   (sel[g]),
                .i_tok   (tok[g]),
                .o_tok   (tok[g+1]),
                .o_owner (owners[g])
            );
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept && keep) n_state = S_SWEEP;
            S_SWEEP: n_state = S_SCAN;
            S_SCAN:  n_state = S_WAIT;
            S_WAIT:  if (r_cnt == 11'(WALK)) n_state = S_APPLY;
            S_APPLY: n_state = S_REPLY;
            S_REPLY: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_APPLY)
                    && ((r_msg.cmd == CMD_DIS) ? r_pick_ok : to_me);
            if (r_state == S_SCAN) r_cnt <= 11'd1;
            else if (r_state == S_WAIT) r_cnt <= r_cnt + 11'd1;
        end
    end

    // datapath registers (walk result is taken when r_cnt reaches WALK)
    always_ff @(posedge i_clk) begin
        if (accept) r_msg <= i_in;
        if (r_state == S_SWEEP) r_grant <= grant;
        if (r_state == S_WAIT && r_cnt == 11'(WALK)) begin
            r_pick_ok <= tok[POOL_SIZE].own_hit || tok[POOL_SIZE].free_hit
                      || tok[POOL_SIZE].exp_hit;
            r_pick <= tok[POOL_SIZE].own_hit ? tok[POOL_SIZE].own_idx
                    : tok[POOL_SIZE].free_hit ? tok[POOL_SIZE].free_idx
                    : tok[POOL_SIZE].exp_idx;
            r_nak <= !addr_ok || (r_msg.client_id == 32'd0)
                  || (owners[aidx] != r_msg.client_id);
        end
        if (r_state == S_APPLY) begin
            r_out.reply_client <= r_msg.client_id;
            if (r_msg.cmd == CMD_DIS) begin
                r_out.reply_kind   <= KIND_OFR;
                r_out.reply_addr   <= 32'(r_pick) + 32'd1;
                r_out.reply_expiry <= r_grant;
            end else begin
                r_out.reply_kind   <= r_nak ? KIND_NAK : KIND_ACK;
                r_out.reply_addr   <= r_msg.req_addr;
                r_out.reply_expiry <= r_nak ? 32'd0 : r_grant;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

`ifndef SYNTHESIS
    a_valid_after_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == S_APPLY)
        else $error("reply strobe without apply");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REPLY) |=> !busy)
        else $error("controller did not return to idle");
    a_nak_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.reply_kind == KIND_NAK) |-> o_out.reply_expiry == 32'd0)
        else $error("refusal with nonzero expiry");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the lease pool server
// Queue-fed command driver, strobe monitor, in-bench lease pool predictor.
// Directed beats, then random lease traffic, some beats malformed, over several configs.
// ----------------------------------------------------------------------------
module tb_top;
    import dlps_pkg::*;

    localparam int NPOOL = 64;
    localparam int DRAIN = NPOOL + 20;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in_beat i_in = '0;
    logic o_valid;
    t_out_beat o_out;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    always #1 i_clk = ~i_clk;

    dhcp_lease_pool_server i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_in(i_in), .o_valid(o_valid), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [31:0] srv_id;
    logic [30:0] lease_def, lease_hi, lease_lo;
    t_status     pool_st [NPOOL];
    logic [31:0] pool_dl [NPOOL];
    logic [31:0] pool_own [NPOOL];

    t_in_beat  msg_q[$];
    t_out_beat reply_q[$];
    int        errors = 0;
    int        gap_pct = 0;
    bit        drv_on = 1'b0;

    // deadline granted for a message at 'now' asking for 'want'
    function automatic logic [31:0] lease_end(logic [30:0] now, logic [30:0] want);
        longint x;
        if (want == 0) return {1'b0, now} + {1'b0, lease_def};
        x = longint'(want) - longint'(now);
        if (x > longint'(lease_hi)) return {1'b0, now} + {1'b0, lease_hi};
        if (x < longint'(lease_lo)) return {1'b0, now} + {1'b0, lease_lo};
        return {1'b0, want};
    endfunction

    // apply one accepted message to the pool model; queue the reply if any
    task automatic pool_apply(input t_in_beat m);
        int pick;
        t_out_beat r;
        pick = -1;
        if (m.cmd == CMD_DIS && !m.dest_broadcast) return;
        if (m.cmd == CMD_REQ && m.dest_broadcast) return;
        if (m.cmd != CMD_DIS && m.cmd != CMD_REQ) return;
        // expiry sweep
        for (int k = 0; k < NPOOL; k++)
            if (pool_dl[k] != 0 && pool_dl[k] <= {1'b0, m.msg_time}) begin
                if (pool_st[k] == ST_PENDING) begin
                    pool_st[k] = ST_FREE;
                    pool_own[k] = '0;
                end else begin
                    pool_st[k] = ST_EXPIRED;
                end
                pool_dl[k] = '0;
            end
        if (m.cmd == CMD_DIS) begin
            if (m.client_id != 0)
                for (int k = 0; k < NPOOL; k++)
                    if (pick < 0 && pool_own[k] == m.client_id) pick = k;
            for (int k = 0; k < NPOOL; k++)
                if (pick < 0 && pool_st[k] == ST_FREE) pick = k;
            for (int k = 0; k < NPOOL; k++)
                if (pick < 0 && pool_st[k] == ST_EXPIRED) pick = k;
            if (pick < 0) return;
            pool_st[pick] = ST_PENDING;
            pool_dl[pick] = lease_end(m.msg_time, m.req_expiry);
            pool_own[pick] = m.client_id;
            r.reply_kind = KIND_OFR;
            r.reply_client = m.client_id;
            r.reply_addr = 32'(pick + 1);
            r.reply_expiry = pool_dl[pick];
            reply_q.push_back(r);
        end else if (m.dest_id == srv_id) begin
            r.reply_client = m.client_id;
            r.reply_addr = m.req_addr;
            if (m.req_addr < 1 || m.req_addr > NPOOL || m.client_id == 0 ||
                pool_own[m.req_addr - 1] != m.client_id) begin
                r.reply_kind = KIND_NAK;
                r.reply_expiry = '0;
            end else begin
                pick = int'(m.req_addr - 32'd1);
                pool_st[pick] = ST_OCCUPIED;
                pool_dl[pick] = lease_end(m.msg_time, m.req_expiry);
                r.reply_kind = KIND_ACK;
                r.reply_expiry = pool_dl[pick];
            end
            reply_q.push_back(r);
        end else if (m.client_id != 0) begin
            // request to another server: drop this client's pending offers
            for (int k = 0; k < NPOOL; k++)
                if (pool_own[k] == m.client_id && pool_st[k] == ST_PENDING) begin
                    pool_st[k] = ST_FREE;
                    pool_dl[k] = '0;
                    pool_own[k] = '0;
                end
        end
    endtask

    // driver: one beat per accepted start, random gaps
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            pool_apply(i_in);
            void'(msg_q.pop_front());
        end
        if (drv_on && msg_q.size() > 0 && $urandom_range(99) >= gap_pct) begin
            // head of the queue is the beat on the ports until accepted
            start <= 1'b1;
            i_in <= msg_q[0];
        end else if (!(start && busy)) begin
            start <= 1'b0;
        end
    end

    // monitor: each strobe is one reply beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (reply_q.size() == 0) begin
                $display("%0t: unexpected reply beat, actual %p", $time, o_out);
                errors++;
            end else begin
                if (o_out.reply_kind !== reply_q[0].reply_kind ||
                    o_out.reply_client !== reply_q[0].reply_client ||
                    o_out.reply_addr !== reply_q[0].reply_addr ||
                    o_out.reply_expiry !== reply_q[0].reply_expiry) begin
                    $display("%0t: reply mismatch, expected %p actual %p",
                             $time, reply_q[0], o_out);
                    errors++;
                end
                void'(reply_q.pop_front());
            end
        end
    end

    task automatic cfg_write(input t_reg idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_SERVER_ID: srv_id = val;
            REG_LEASE_DEF: lease_def = val[30:0];
            REG_LEASE_MAX: lease_hi = val[30:0];
            default:       lease_lo = val[30:0];
        endcase
    endtask

    task automatic wait_idle();
        while (msg_q.size() > 0 || start) @(posedge i_clk);
        while (reply_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    logic [30:0] clock_now = 31'd100;

    function automatic t_in_beat mk(t_cmd c, logic [31:0] cl, logic bc, logic [31:0] d,
                                    logic [31:0] a, logic [30:0] w);
        t_in_beat m;
        m.cmd = c;
        m.msg_time = clock_now;
        m.client_id = cl;
        m.dest_broadcast = bc;
        m.dest_id = d;
        m.req_addr = a;
        m.req_expiry = w;
        return m;
    endfunction

    // random lease traffic; small client set so owners collide and offers renew
    task automatic random_burst(input int n);
        t_in_beat m;
        logic [31:0] cl;
        int sel;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) clock_now = 31'($urandom);
            else clock_now = 31'(clock_now + $urandom_range(200));
            sel = $urandom_range(99);
            cl = ($urandom_range(19) == 0) ? $urandom : $urandom_range(40);
            if (sel < 40) begin
                m = mk(CMD_DIS, cl, 1'b1, $urandom, $urandom,
                       ($urandom_range(2) == 0) ? 31'd0
                       : 31'(clock_now + $urandom_range(5000)));
            end else if (sel < 80) begin
                m = mk(CMD_REQ, cl, 1'b0, srv_id,
                       ($urandom_range(9) == 0) ? $urandom : $urandom_range(NPOOL + 1),
                       ($urandom_range(3) == 0) ? 31'($urandom)
                       : 31'(clock_now + $urandom_range(90000)));
            end else if (sel < 90) begin
                m = mk(CMD_REQ, cl, 1'b0, $urandom, $urandom_range(NPOOL),
                       31'($urandom));
            end else begin
                m = mk(t_cmd'(2'($urandom_range(3))), cl, 1'($urandom_range(1)),
                       $urandom, $urandom, 31'($urandom));
                m.msg_time = 31'($urandom);
            end
            msg_q.push_back(m);
        end
    endtask

    initial begin
        srv_id = 32'd1;
        lease_def = 31'd3600;
        lease_hi = 31'd86400;
        lease_lo = 31'd60;
        for (int k = 0; k < NPOOL; k++) begin
            pool_st[k] = ST_FREE;
            pool_dl[k] = '0;
            pool_own[k] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        drv_on = 1'b1;

        // directed: offer, ack, nak, release, ignored beats, field extremes
        msg_q.push_back(mk(CMD_DIS, 32'd5, 1'b1, '0, '0, '0));
        msg_q.push_back(mk(CMD_REQ, 32'd5, 1'b0, 32'd1, 32'd1, '0));
        msg_q.push_back(mk(CMD_DIS, 32'hFFFF_FFFF, 1'b1, '1, '1, 31'h7FFF_FFFF));
        msg_q.push_back(mk(CMD_REQ, 32'hFFFF_FFFF, 1'b0, 32'd1, 32'd2, 31'd150));
        msg_q.push_back(mk(CMD_REQ, 32'd5, 1'b0, 32'd1, 32'd0, '0));
        msg_q.push_back(mk(CMD_REQ, 32'd5, 1'b0, 32'd1, 32'd65, '0));
        msg_q.push_back(mk(CMD_REQ, 32'd5, 1'b0, 32'd1, '1, '0));
        msg_q.push_back(mk(CMD_REQ, 32'd9, 1'b0, 32'd1, 32'd1, '0));
        msg_q.push_back(mk(CMD_DIS, 32'd0, 1'b1, '0, '0, '0));
        msg_q.push_back(mk(CMD_REQ, 32'd0, 1'b0, 32'd1, 32'd3, '0));
        msg_q.push_back(mk(CMD_DIS, 32'd7, 1'b1, '0, '0, 31'd400));
        msg_q.push_back(mk(CMD_REQ, 32'd7, 1'b0, 32'd2, 32'd4, '0));
        msg_q.push_back(mk(CMD_DIS, 32'd7, 1'b0, 32'd1, '0, '0));
        msg_q.push_back(mk(CMD_REQ, 32'd5, 1'b1, 32'd1, 32'd1, '0));
        msg_q.push_back(mk(CMD_OT2, 32'd5, 1'b1, 32'd1, 32'd1, '0));
        msg_q.push_back(mk(CMD_OT3, 32'd5, 1'b0, 32'd1, 32'd1, '0));
        clock_now = 31'h7FFF_FF00;
        msg_q.push_back(mk(CMD_DIS, 32'd11, 1'b1, '0, '0, '0));
        clock_now = 31'd50;
        msg_q.push_back(mk(CMD_DIS, 32'd12, 1'b1, '0, '0, '0));
        // pool exhaustion: more clients than entries at one time
        for (int c = 100; c < 100 + NPOOL + 3; c++)
            msg_q.push_back(mk(CMD_DIS, 32'(c), 1'b1, '0, '0, 31'd1_000_000));
        wait_idle();

        gap_pct = 7;
        random_burst(200);
        wait_idle();

        cfg_write(REG_SERVER_ID, 32'hFFFF_FFFF);
        cfg_write(REG_LEASE_DEF, 32'h7FFF_FFFF);
        cfg_write(REG_LEASE_MAX, 32'h7FFF_FFFF);
        cfg_write(REG_LEASE_MIN, 32'd1);
        gap_pct = 71;
        random_burst(200);
        wait_idle();

        // out-of-range: min above max, zero lease, server id 0
        cfg_write(REG_SERVER_ID, 32'd0);
        cfg_write(REG_LEASE_DEF, 32'd0);
        cfg_write(REG_LEASE_MAX, 32'd10);
        cfg_write(REG_LEASE_MIN, 32'd500);
        gap_pct = 0;
        random_burst(100);
        wait_idle();

        cfg_write(REG_SERVER_ID, 32'd1);
        cfg_write(REG_LEASE_DEF, 32'd300);
        cfg_write(REG_LEASE_MAX, 32'd2000);
        cfg_write(REG_LEASE_MIN, 32'd20);
        random_burst(120);
        wait_idle();

        if (errors == 0 && reply_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
